>>> rtl/core/scc_pkg.sv
// Package: shared types and constants for the strongly connected components block.
package scc_pkg;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_ROOT,
    ST_ENTER,
    ST_EDGE_RD,
    ST_EDGE_EV,
    ST_FINISH,
    ST_POP,
    ST_RET,
    ST_SUCC_RD,
    ST_SUCC_EV,
    ST_OUT_RD,
    ST_OUT_EV,
    ST_OUT,
    ST_CLEAR
  } scc_state_e;

  typedef struct packed {
    logic load;
    logic clr_all;
    logic root_start;
    logic root_adv;
    logic enter_do;
    logic edge_rd;
    logic edge_ev;
    logic pop_do;
    logic ret_do;
    logic succ_rd;
    logic succ_ev;
    logic succ_adv;
    logic out_start;
    logic out_rd;
    logic out_ev;
    logic out_adv;
    logic clr_step;
  } scc_cmd_t;

  typedef struct packed {
    logic root_done;
    logic root_visited;
    logic frames_empty;
    logic edge_avail;
    logic edge_new;
    logic is_root;
    logic pop_last;
    logic succ_done;
    logic succ_vnext;
    logic out_done;
    logic clr_done;
  } scc_stat_t;

endpackage

>>> rtl/core/scc_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module scc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> rtl/core/scc_ctrl.sv
// Controller: sequences load, search, successor scan, emit and clear.
module scc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  logic              in_last_i,
  input  logic              out_ready_i,
  input  scc_pkg::scc_stat_t stat_i,
  output scc_pkg::scc_cmd_t  cmd_o,
  output logic              in_ready_o,
  output logic              out_valid_o
);
  import scc_pkg::*;

  scc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:    if (in_fire_i && in_last_i) state_d = ST_ROOT;
      ST_ROOT: begin
        if (stat_i.root_done) state_d = ST_SUCC_RD;
        else if (!stat_i.root_visited) state_d = ST_ENTER;
      end
      ST_ENTER:   state_d = ST_EDGE_RD;
      ST_EDGE_RD: state_d = stat_i.edge_avail ? ST_EDGE_EV : ST_FINISH;
      ST_EDGE_EV: state_d = stat_i.edge_new ? ST_ENTER : ST_EDGE_RD;
      ST_FINISH:  state_d = stat_i.is_root ? ST_POP : ST_RET;
      ST_POP:     if (stat_i.pop_last) state_d = ST_RET;
      ST_RET:     state_d = stat_i.frames_empty ? ST_ROOT : ST_EDGE_RD;
      ST_SUCC_RD: begin
        if (stat_i.succ_done) state_d = ST_OUT_RD;
        else if (!stat_i.succ_vnext) state_d = ST_SUCC_EV;
      end
      ST_SUCC_EV: state_d = ST_SUCC_RD;
      ST_OUT_RD:  state_d = stat_i.out_done ? ST_CLEAR : ST_OUT_EV;
      ST_OUT_EV:  state_d = ST_OUT;
      ST_OUT:     if (out_ready_i) state_d = ST_OUT_RD;
      ST_CLEAR:   if (stat_i.clr_done) state_d = ST_LOAD;
      default:    state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_fire_i;
        cmd_o.root_start = in_fire_i && in_last_i;
      end
      ST_ROOT:    cmd_o.root_adv = !stat_i.root_done && stat_i.root_visited;
      ST_ENTER:   cmd_o.enter_do = 1'b1;
      ST_EDGE_RD: cmd_o.edge_rd = stat_i.edge_avail;
      ST_EDGE_EV: cmd_o.edge_ev = 1'b1;
      ST_FINISH:  ;
      ST_POP:     cmd_o.pop_do = 1'b1;
      ST_RET:     cmd_o.ret_do = 1'b1;
      ST_SUCC_RD: begin
        cmd_o.succ_rd = !stat_i.succ_done && !stat_i.succ_vnext;
        cmd_o.succ_adv = !stat_i.succ_done && stat_i.succ_vnext;
        cmd_o.out_start = stat_i.succ_done;
      end
      ST_SUCC_EV: cmd_o.succ_ev = 1'b1;
      ST_OUT_RD:  cmd_o.out_rd = !stat_i.out_done;
      ST_OUT_EV:  cmd_o.out_ev = 1'b1;
      ST_OUT: begin
        out_valid_o = 1'b1;
        cmd_o.out_adv = out_ready_i;
      end
      ST_CLEAR:   cmd_o.clr_step = 1'b1;
      default:    ;
    endcase
  end
endmodule

>>> rtl/core/scc_dp.sv
// Datapath: graph storage, Tarjan search stacks, component tables, result fields.
module scc_dp #(
  parameter int MaxVertices = 32,
  parameter int MaxDegree   = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scc_pkg::scc_cmd_t  cmd_i,
  output scc_pkg::scc_stat_t stat_o,
  input  logic [5:0]        vertex_count_i,
  input  logic              has_edge_i,
  input  logic [4:0]        src_i,
  input  logic [4:0]        dst_i,
  output logic [4:0]        vertex_o,
  output logic [4:0]        component_o,
  output logic [4:0]        topo_position_o,
  output logic [5:0]        component_count_o,
  output logic [31:0]       successor_mask_o,
  output logic              dropped_o,
  output logic              final_res_o
);
  import scc_pkg::*;

  localparam int VW = $clog2(MaxVertices);
  localparam int CW = VW + 1;
  localparam int DW = $clog2(MaxDegree + 1);
  localparam int IW = (MaxDegree > 1) ? $clog2(MaxDegree) : 1;
  localparam int TD = MaxVertices * (2 ** IW);
  localparam int TW = $clog2(TD);

  logic [6:0] n_full;
  logic [CW-1:0] n_w;
  assign n_full = (7'(vertex_count_i) > 7'(MaxVertices)) ? 7'(MaxVertices)
                                                         : 7'(vertex_count_i);
  assign n_w = CW'(n_full);

  logic [DW-1:0] deg_q [MaxVertices];
  logic [MaxVertices-1:0] visited_q, finished_q;
  logic [CW-1:0] order_q [MaxVertices];
  logic [CW-1:0] low_q [MaxVertices];
  logic [VW-1:0] vstack_q [MaxVertices];
  logic [VW-1:0] fvert_q [MaxVertices];
  logic [DW-1:0] fnext_q [MaxVertices];
  logic [VW-1:0] comp_q [MaxVertices];
  logic [MaxVertices-1:0] csucc_q [MaxVertices];
  logic [CW-1:0] time_q, top_q, frames_q, done_q;
  logic drop_q;
  logic [CW-1:0] root_q, enter_v_q, sv_q;
  logic [DW-1:0] si_q;
  logic [CW-1:0] clr_q;

  // Table
  logic          t_we;
  logic [TW-1:0] t_waddr, t_raddr;
  logic [VW-1:0] t_wdata, t_rdata;

  scc_ram #(.Width(VW), .Depth(TD)) u_table (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .wdata_i(t_wdata),
    .raddr_i(t_raddr), .rdata_o(t_rdata)
  );

  logic ok_w;
  logic src_rng, dst_rng;
  assign src_rng = 7'(src_i) < n_full;
  assign dst_rng = 7'(dst_i) < n_full;
  logic [VW-1:0] s_idx;
  assign s_idx = VW'(src_i);
  assign ok_w = src_rng && dst_rng && (deg_q[s_idx] < DW'(MaxDegree));

  logic [VW-1:0] tv, fv_top;
  logic [DW-1:0] fi_top;
  assign tv = fvert_q[VW'(frames_q - 1'b1)];
  assign fi_top = fnext_q[VW'(frames_q - 1'b1)];
  assign fv_top = tv;
  logic [VW-1:0] x_w;
  assign x_w = t_rdata;
  logic x_in;
  assign x_in = CW'(x_w) < n_w;
  logic [VW-1:0] pop_u;
  assign pop_u = vstack_q[VW'(top_q - 1'b1)];
  logic [VW-1:0] sv_idx;
  assign sv_idx = VW'(sv_q);
  logic [VW-1:0] par_v;
  assign par_v = fvert_q[VW'(frames_q - CW'(2))];

  always_comb begin
    t_we = cmd_i.load && has_edge_i && ok_w;
    t_waddr = TW'({s_idx, IW'(deg_q[s_idx])});
    t_wdata = VW'(dst_i);
    if (cmd_i.succ_rd) t_raddr = TW'({sv_idx, IW'(si_q)});
    else t_raddr = TW'({fv_top, IW'(fi_top)});
  end

  assign stat_o.root_done = root_q >= n_w;
  assign stat_o.root_visited = visited_q[VW'(root_q)];
  assign stat_o.frames_empty = frames_q == CW'(1);
  assign stat_o.edge_avail = fi_top < deg_q[tv];
  assign stat_o.edge_new = x_in && !visited_q[x_w];
  assign stat_o.is_root = low_q[tv] == order_q[tv];
  assign stat_o.pop_last = pop_u == tv;
  assign stat_o.succ_done = sv_q >= n_w;
  assign stat_o.succ_vnext = si_q >= deg_q[sv_idx];
  assign stat_o.out_done = sv_q >= n_w;
  assign stat_o.clr_done = clr_q == CW'(MaxVertices - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxVertices; k++) begin
        deg_q[k] <= '0;
        csucc_q[k] <= '0;
      end
      visited_q <= '0;
      finished_q <= '0;
      time_q <= '0;
      top_q <= '0;
      frames_q <= '0;
      done_q <= '0;
      drop_q <= 1'b0;
      root_q <= '0;
      enter_v_q <= '0;
      sv_q <= '0;
      si_q <= '0;
      clr_q <= '0;
    end else begin
      if (cmd_i.load && has_edge_i) begin
        if (ok_w) deg_q[s_idx] <= deg_q[s_idx] + 1'b1;
        else drop_q <= 1'b1;
      end
      if (cmd_i.root_start) begin
        root_q <= '0;
        enter_v_q <= '0;
      end
      if (cmd_i.root_adv) begin
        root_q <= root_q + 1'b1;
        enter_v_q <= root_q + 1'b1;
      end
      if (cmd_i.enter_do) begin
        visited_q[VW'(enter_v_q)] <= 1'b1;
        order_q[VW'(enter_v_q)] <= time_q;
        low_q[VW'(enter_v_q)] <= time_q;
        time_q <= time_q + 1'b1;
        vstack_q[VW'(top_q)] <= VW'(enter_v_q);
        top_q <= top_q + 1'b1;
        fvert_q[VW'(frames_q)] <= VW'(enter_v_q);
        fnext_q[VW'(frames_q)] <= '0;
        frames_q <= frames_q + 1'b1;
      end
      if (cmd_i.edge_rd) fnext_q[VW'(frames_q - 1'b1)] <= fi_top + 1'b1;
      if (cmd_i.edge_ev && x_in) begin
        if (!visited_q[x_w]) enter_v_q <= CW'(x_w);
        else if (!finished_q[x_w] && order_q[x_w] < low_q[tv]) low_q[tv] <= order_q[x_w];
      end
      if (cmd_i.pop_do) begin
        finished_q[pop_u] <= 1'b1;
        comp_q[pop_u] <= VW'(done_q);
        top_q <= top_q - 1'b1;
        if (pop_u == tv) done_q <= done_q + 1'b1;
      end
      if (cmd_i.ret_do) begin
        frames_q <= frames_q - 1'b1;
        if (frames_q != CW'(1) && low_q[tv] < low_q[par_v]) low_q[par_v] <= low_q[tv];
        if (frames_q == CW'(1)) begin
          root_q <= root_q + 1'b1;
          enter_v_q <= root_q + 1'b1;
          if (root_q + 1'b1 >= n_w) begin
            sv_q <= '0;
            si_q <= '0;
          end
        end
      end
      if (cmd_i.succ_rd) si_q <= si_q + 1'b1;
      if (cmd_i.succ_ev) begin
        if (x_in && comp_q[x_w] != comp_q[sv_idx])
          csucc_q[comp_q[sv_idx]][comp_q[x_w]] <= 1'b1;
      end
      if (cmd_i.succ_adv) begin
        sv_q <= sv_q + 1'b1;
        si_q <= '0;
      end
      if (cmd_i.out_start) sv_q <= '0;
      if (cmd_i.out_adv) sv_q <= sv_q + 1'b1;
      if (cmd_i.clr_step) begin
        deg_q[VW'(clr_q)] <= '0;
        csucc_q[VW'(clr_q)] <= '0;
        clr_q <= clr_q + 1'b1;
        if (stat_o.clr_done) begin
          clr_q <= '0;
          visited_q <= '0;
          finished_q <= '0;
          time_q <= '0;
          top_q <= '0;
          done_q <= '0;
          drop_q <= 1'b0;
          root_q <= '0;
          sv_q <= '0;
        end
      end
    end
  end

  // Output registers
  logic [VW-1:0] c_w;
  assign c_w = comp_q[sv_idx];
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ev) begin
      vertex_o <= 5'(sv_q);
      component_o <= 5'(c_w);
      topo_position_o <= 5'(done_q - 1'b1 - CW'(c_w));
      component_count_o <= 6'(done_q);
      successor_mask_o <= 32'(csucc_q[c_w]);
      dropped_o <= drop_q;
      final_res_o <= (sv_q + 1'b1) == n_w;
    end
  end
endmodule

>>> rtl/core/strongly_connected_components_top.sv
// Top level: stream wrapper for the strongly connected components block.
// Usage: set vertex_count through cfg_we_i/cfg_wdata_i while idle, then
// stream one edge per transfer on s_axis; tuser carries has_edge, tlast
// ends the graph. Edges load at one per cycle. After tlast the Tarjan
// search runs on a controller plus datapath (one table read port), then
// comes a successor scan over the edges. One result per vertex leaves on
// m_axis in ascending order, tlast on the final one; the next result is
// not read until the current one is taken. A stalled receiver holds the
// result register and the controller. Afterwards a clear sweep over all
// MAX_VERTICES entries empties degree counts and successor sets;
// s_axis_tready stays low from tlast until the sweep ends. Reset clears
// control state and sets vertex_count to 32.
module strongly_connected_components_top #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_DEGREE   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // src[4:0], dst[9:5], pad
  input  logic        s_axis_tuser,  // has_edge
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // vertex, component, topo_position,
                                     // component_count, successor_mask, pad
  output logic        m_axis_tuser,  // dropped
  output logic        m_axis_tlast   // final_res
);
  import scc_pkg::*;

  logic [5:0] vc_q;
  scc_cmd_t  cmd;
  scc_stat_t stat;
  logic [4:0]  r_vertex, r_comp, r_topo;
  logic [5:0]  r_count;
  logic [31:0] r_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 6'd32;
    end else if (cfg_we_i) begin
      vc_q <= cfg_wdata_i;
    end
  end

  scc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i(s_axis_tvalid && s_axis_tready),
    .in_last_i(s_axis_tlast),
    .out_ready_i(m_axis_tready),
    .stat_i(stat), .cmd_o(cmd),
    .in_ready_o(s_axis_tready), .out_valid_o(m_axis_tvalid)
  );

  scc_dp #(.MaxVertices(MAX_VERTICES), .MaxDegree(MAX_DEGREE)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .vertex_count_i(vc_q),
    .has_edge_i(s_axis_tuser),
    .src_i(s_axis_tdata[4:0]), .dst_i(s_axis_tdata[9:5]),
    .vertex_o(r_vertex), .component_o(r_comp), .topo_position_o(r_topo),
    .component_count_o(r_count), .successor_mask_o(r_mask),
    .dropped_o(m_axis_tuser), .final_res_o(m_axis_tlast)
  );

  assign m_axis_tdata = {3'd0, r_mask, r_count, r_topo, r_comp, r_vertex};
endmodule
